FILE: hdl/qhpr_pkg.sv
package qhpr_pkg;

  // angle word of the CORDIC units, 2^-16 degree per LSB
  localparam int ZW = 26;
  // heading word, wide enough for offset and deviation excursions
  localparam int HW = 28;
  localparam int FRAC_W = 22;
  localparam int PROD_W = 32;
  localparam int ABS_W = 31;
  localparam int QUO_W = 26;
  localparam int CHUNK_W = 24;
  localparam int GAIN_W = 30;
  localparam int QUEUE_DEPTH = 4;

  localparam logic signed [ZW-1:0] ANG_90_Z = 26'sd5898240;
  localparam logic signed [HW-1:0] ANG_45_H = 28'sd2949120;
  localparam logic signed [HW-1:0] ANG_360_H = 28'sd23592960;
  localparam logic signed [HW-1:0] ANG_720_H = 28'sd47185920;
  localparam logic signed [HW-1:0] ANG_1080_H = 28'sd70778880;

  localparam logic [GAIN_W-1:0] INV_GAIN = 30'd652032874;
  localparam logic [31:0] DIV45_M = 32'd3054198966;
  localparam int DIV45_S = 37;

  localparam logic [31:0] DEV_LOW_RST = 32'h050401FE;
  localparam logic [31:0] DEV_HIGH_RST = 32'hFF040503;
  localparam logic [8:0] OFFSET_RST = 9'd90;
  localparam logic DEV_EN_RST = 1'b1;

  typedef enum logic [1:0] {
    REG_DEV_LOW  = 2'd0,
    REG_DEV_HIGH = 2'd1,
    REG_OFFSET   = 2'd2,
    REG_DEV_EN   = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [31:0] dev_low;
    logic [31:0] dev_high;
    logic [8:0]  offset;
    logic        dev_en;
  } cfg_t;

  function automatic logic signed [ZW-1:0] atan_unit(int i);
    logic signed [ZW-1:0] v;
    case (i)
      0: v = 26'sd2949120;
      1: v = 26'sd1740967;
      2: v = 26'sd919879;
      3: v = 26'sd466945;
      4: v = 26'sd234379;
      5: v = 26'sd117304;
      6: v = 26'sd58666;
      7: v = 26'sd29335;
      8: v = 26'sd14668;
      9: v = 26'sd7334;
      10: v = 26'sd3667;
      11: v = 26'sd1833;
      12: v = 26'sd917;
      13: v = 26'sd458;
      14: v = 26'sd229;
      15: v = 26'sd115;
      16: v = 26'sd57;
      17: v = 26'sd29;
      18: v = 26'sd14;
      19: v = 26'sd7;
      20: v = 26'sd4;
      21: v = 26'sd2;
      22: v = 26'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [7:0] dev_entry(cfg_t cfg, logic [2:0] k);
    logic [31:0] r;
    r = k[2] ? cfg.dev_high : cfg.dev_low;
    return $signed(r[{k[1:0], 3'b000} +: 8]);
  endfunction

endpackage

FILE: hdl/qhpr_front.sv
module qhpr_front #(
  parameter int QUAT_FRAC_BITS = 14,
  parameter int BW = 34
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  output logic                 full_o,
  input  logic signed [15:0]   quat_w_i,
  input  logic signed [15:0]   quat_x_i,
  input  logic signed [15:0]   quat_y_i,
  input  logic signed [15:0]   quat_z_i,
  input  logic                 qfull_i,
  output logic                 wr_o,
  output logic [5*BW-1:0]      vec_o
);

  logic valid_q;
  logic adv;
  logic signed [31:0] ww_q, xx_q, yy_q, zz_q, xy_q, wz_q, xz_q, wy_q, wx_q, yz_q;
  logic signed [BW-1:0] gx, gy, gz, yn, yd;
  logic signed [BW-1:0] one;

  function automatic logic signed [BW-1:0] sx(logic signed [31:0] p);
    return {{(BW-32){p[31]}}, p};
  endfunction

  assign adv = !valid_q || !qfull_i;
  assign full_o = !adv;
  assign wr_o = valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv) begin
      valid_q <= push_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && adv) begin
      ww_q <= quat_w_i * quat_w_i;
      xx_q <= quat_x_i * quat_x_i;
      yy_q <= quat_y_i * quat_y_i;
      zz_q <= quat_z_i * quat_z_i;
      xy_q <= quat_x_i * quat_y_i;
      wz_q <= quat_w_i * quat_z_i;
      xz_q <= quat_x_i * quat_z_i;
      wy_q <= quat_w_i * quat_y_i;
      wx_q <= quat_w_i * quat_x_i;
      yz_q <= quat_y_i * quat_z_i;
    end
  end

  assign one = {{(BW-1){1'b0}}, 1'b1} << (2 * QUAT_FRAC_BITS);

  always_comb begin
    gx = (sx(xz_q) - sx(wy_q)) <<< 1;
    gy = (sx(wx_q) + sx(yz_q)) <<< 1;
    gz = sx(ww_q) - sx(xx_q) - sx(yy_q) + sx(zz_q);
    yn = (sx(xy_q) - sx(wz_q)) <<< 1;
    yd = ((sx(ww_q) + sx(xx_q)) <<< 1) - one;
  end

  assign vec_o = {yd, yn, gz, gy, gx};

endmodule

FILE: hdl/qhpr_fifo.sv
module qhpr_fifo #(
  parameter int W = 170,
  parameter int DEPTH = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         wr_i,
  input  logic [W-1:0] wdata_i,
  output logic         full_o,
  input  logic         rd_i,
  output logic [W-1:0] rdata_o,
  output logic         empty_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0] mem_q [DEPTH];
  logic [AW-1:0] wp_q, rp_q;
  logic [CW-1:0] cnt_q;
  logic do_wr, do_rd;

  assign full_o = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_wr = wr_i && !full_o;
  assign do_rd = rd_i && !empty_o;
  assign rdata_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (do_wr) begin
        wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
      end
      if (do_rd) begin
        rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wp_q] <= wdata_i;
    end
  end

endmodule

FILE: hdl/qhpr_cordic.sv
module qhpr_cordic #(
  parameter int W = 37,
  parameter int STEPS = 16
) (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic signed [W-1:0]            x_i,
  input  logic signed [W-1:0]            y_i,
  output logic signed [qhpr_pkg::ZW-1:0] ang_o,
  output logic signed [W-1:0]            mag_o
);

  localparam int ZW = qhpr_pkg::ZW;

  logic signed [W-1:0] x0, y0;
  logic signed [ZW-1:0] z0;
  logic zero0;

  logic signed [W-1:0] x_q [STEPS];
  logic signed [W-1:0] y_q [STEPS];
  logic signed [ZW-1:0] z_q [STEPS];
  logic zf_q [STEPS];

  // fold the left half-plane onto the right before the micro-rotations
  always_comb begin
    zero0 = (x_i == '0) && (y_i == '0);
    x0 = x_i;
    y0 = y_i;
    z0 = '0;
    if (x_i[W-1]) begin
      if (!y_i[W-1]) begin
        x0 = y_i;
        y0 = -x_i;
        z0 = qhpr_pkg::ANG_90_Z;
      end else begin
        x0 = -y_i;
        y0 = x_i;
        z0 = -qhpr_pkg::ANG_90_Z;
      end
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic signed [W-1:0] xi, yi;
    logic signed [ZW-1:0] zi;
    logic zfi;
    if (i == 0) begin : g_first
      assign xi = x0;
      assign yi = y0;
      assign zi = z0;
      assign zfi = zero0;
    end else begin : g_next
      assign xi = x_q[i-1];
      assign yi = y_q[i-1];
      assign zi = z_q[i-1];
      assign zfi = zf_q[i-1];
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!yi[W-1]) begin
          x_q[i] <= xi + (yi >>> i);
          y_q[i] <= yi - (xi >>> i);
          z_q[i] <= zi + qhpr_pkg::atan_unit(i);
        end else begin
          x_q[i] <= xi - (yi >>> i);
          y_q[i] <= yi + (xi >>> i);
          z_q[i] <= zi - qhpr_pkg::atan_unit(i);
        end
        zf_q[i] <= zfi;
      end
    end
  end

  assign ang_o = zf_q[STEPS-1] ? '0 : z_q[STEPS-1];
  assign mag_o = x_q[STEPS-1];

endmodule

FILE: hdl/qhpr_back.sv
module qhpr_back #(
  parameter int CORDIC_STEPS = 16,
  parameter int BW = 34
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  qhpr_pkg::cfg_t        cfg_i,
  input  logic                  qempty_i,
  input  logic [5*BW-1:0]       qdata_i,
  output logic                  qrd_o,
  input  logic                  pop_i,
  output logic                  empty_o,
  output logic [15:0]           yaw_o,
  output logic signed [14:0]    pitch_o,
  output logic signed [14:0]    roll_o
);

  localparam int VW = BW + 3;
  localparam int ZW = qhpr_pkg::ZW;
  localparam int HW = qhpr_pkg::HW;
  localparam int CH = qhpr_pkg::CHUNK_W;
  localparam int GW = qhpr_pkg::GAIN_W;
  localparam int NCH = (VW - 1 + CH - 1) / CH;
  localparam int SUM_W = NCH * CH + GW;
  localparam int L = 2 * CORDIC_STEPS + 2;
  localparam int NDLY = CORDIC_STEPS + 2;
  localparam int YDLY = CORDIC_STEPS - 5;
  localparam int FW = qhpr_pkg::FRAC_W;
  localparam int PW = qhpr_pkg::PROD_W;
  localparam int AW = qhpr_pkg::ABS_W;
  localparam int QW = qhpr_pkg::QUO_W;

  logic en;
  logic [L-1:0] vp_q;
  logic out_valid_q;

  logic signed [BW-1:0] gx, gy, gz, yn, yd;
  logic [2*BW-1:0] nd_q [NDLY];

  logic signed [ZW-1:0] yaw_ang, pa_ang, ra_ang;
  logic signed [VW-1:0] pm_mag, rm_mag;
  logic [CH+GW-1:0] ppp_q [NCH];
  logic [CH+GW-1:0] ppr_q [NCH];
  logic [NCH*CH-1:0] mkp, mkr;
  logic [SUM_W-1:0] sum_p, sum_r;
  logic signed [VW-1:0] mp_q, mr_q;
  logic signed [BW-1:0] num_p, num_r;

  logic signed [HW-1:0] ya_q, yb_q, yc_q, yd_h_q, ye_h_q, yf_h_q, yg_h3_q, yg_h4_q;
  logic signed [HW-1:0] yc_d;
  logic [2:0] seg, seg_q;
  logic [FW-1:0] frac, frac_q;
  logic signed [7:0] d0, d1, ye_d0_q, yf_d0_q;
  logic signed [8:0] diff;
  logic signed [PW-1:0] prod, ye_p_q;
  logic [AW-1:0] abs_p, yf_a_q;
  logic [AW+31:0] recip;
  logic [QW-1:0] yf_q0_q;
  logic yf_neg_q;
  logic [31:0] rem;
  logic [QW-1:0] quo;
  logic signed [HW-1:0] quo_s, h4, hw;
  logic [15:0] ydl_q [YDLY];
  logic signed [ZW-1:0] pa_sat, ra_sat;

  function automatic logic signed [VW-1:0] vx(logic signed [BW-1:0] v);
    return {{3{v[BW-1]}}, v};
  endfunction

  function automatic logic signed [ZW-1:0] sat90(logic signed [ZW-1:0] a);
    if (a > qhpr_pkg::ANG_90_Z) begin
      return qhpr_pkg::ANG_90_Z;
    end else if (a < -qhpr_pkg::ANG_90_Z) begin
      return -qhpr_pkg::ANG_90_Z;
    end
    return a;
  endfunction

  // whole pipeline advances unless a finished result is waiting and not popped
  assign en = !out_valid_q || pop_i;
  assign qrd_o = en && !qempty_i;
  assign empty_o = !out_valid_q;

  assign {yd, yn, gz, gy, gx} = qdata_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vp_q <= {vp_q[L-2:0], qrd_o};
      out_valid_q <= vp_q[L-1];
    end
  end

  qhpr_cordic #(.W(VW), .STEPS(CORDIC_STEPS)) u_yaw (
    .clk_i, .en_i(en), .x_i(vx(yd)), .y_i(vx(yn)), .ang_o(yaw_ang), .mag_o()
  );
  qhpr_cordic #(.W(VW), .STEPS(CORDIC_STEPS)) u_pmag (
    .clk_i, .en_i(en), .x_i(vx(gz)), .y_i(vx(gy)), .ang_o(), .mag_o(pm_mag)
  );
  qhpr_cordic #(.W(VW), .STEPS(CORDIC_STEPS)) u_rmag (
    .clk_i, .en_i(en), .x_i(vx(gz)), .y_i(vx(gx)), .ang_o(), .mag_o(rm_mag)
  );

  // carry the tilt numerators alongside the magnitude pass
  always_ff @(posedge clk_i) begin
    if (en) begin
      nd_q[0] <= {gx, gy};
      for (int k = 1; k < NDLY; k++) begin
        nd_q[k] <= nd_q[k-1];
      end
    end
  end
  assign {num_p, num_r} = nd_q[NDLY-1];

  // inverse gain, split into chunk products then summed
  assign mkp = pm_mag[VW-1] ? '0 : (NCH*CH)'(pm_mag[VW-2:0]);
  assign mkr = rm_mag[VW-1] ? '0 : (NCH*CH)'(rm_mag[VW-2:0]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < NCH; j++) begin
        ppp_q[j] <= mkp[j*CH +: CH] * qhpr_pkg::INV_GAIN;
        ppr_q[j] <= mkr[j*CH +: CH] * qhpr_pkg::INV_GAIN;
      end
    end
  end

  always_comb begin
    sum_p = '0;
    sum_r = '0;
    for (int j = 0; j < NCH; j++) begin
      sum_p = sum_p + (SUM_W'(ppp_q[j]) << (j * CH));
      sum_r = sum_r + (SUM_W'(ppr_q[j]) << (j * CH));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mp_q <= {1'b0, sum_p[GW +: VW-1]};
      mr_q <= {1'b0, sum_r[GW +: VW-1]};
    end
  end

  qhpr_cordic #(.W(VW), .STEPS(CORDIC_STEPS)) u_pang (
    .clk_i, .en_i(en), .x_i(mp_q), .y_i(vx(num_p)), .ang_o(pa_ang), .mag_o()
  );
  qhpr_cordic #(.W(VW), .STEPS(CORDIC_STEPS)) u_rang (
    .clk_i, .en_i(en), .x_i(mr_q), .y_i(vx(num_r)), .ang_o(ra_ang), .mag_o()
  );

  // heading: unwrap, offset, reduce, segment
  always_comb begin
    if (yb_q >= qhpr_pkg::ANG_1080_H) begin
      yc_d = yb_q - qhpr_pkg::ANG_1080_H;
    end else if (yb_q >= qhpr_pkg::ANG_720_H) begin
      yc_d = yb_q - qhpr_pkg::ANG_720_H;
    end else if (yb_q >= qhpr_pkg::ANG_360_H) begin
      yc_d = yb_q - qhpr_pkg::ANG_360_H;
    end else begin
      yc_d = yb_q;
    end
  end

  always_comb begin
    logic signed [HW-1:0] base;
    seg = '0;
    for (int k = 1; k < 8; k++) begin
      if (yc_q >= HW'(k) * qhpr_pkg::ANG_45_H) begin
        seg = 3'(k);
      end
    end
    base = HW'(seg) * qhpr_pkg::ANG_45_H;
    frac = FW'(yc_q - base);
  end

  always_comb begin
    d0 = qhpr_pkg::dev_entry(cfg_i, seg_q);
    d1 = qhpr_pkg::dev_entry(cfg_i, seg_q + 3'd1);
    diff = {d1[7], d1} - {d0[7], d0};
    prod = $signed({1'b0, frac_q}) * diff;
    abs_p = ye_p_q[PW-1] ? AW'(-ye_p_q) : AW'(ye_p_q);
    recip = abs_p * qhpr_pkg::DIV45_M;
  end

  // correct the reciprocal estimate by one, then apply sign toward zero
  always_comb begin
    rem = {1'b0, yf_a_q} - 32'(yf_q0_q) * 32'd45;
    quo = yf_q0_q + QW'(rem >= 32'd45);
    quo_s = yf_neg_q ? -HW'(quo) : HW'(quo);
    h4 = yf_h_q + quo_s + ({{(HW-8){yf_d0_q[7]}}, yf_d0_q} <<< 16);
  end

  always_comb begin
    hw = yg_h3_q;
    if (cfg_i.dev_en) begin
      if (yg_h4_q < 0) begin
        hw = yg_h4_q + qhpr_pkg::ANG_360_H;
      end else if (yg_h4_q >= qhpr_pkg::ANG_360_H) begin
        hw = yg_h4_q - qhpr_pkg::ANG_360_H;
      end else begin
        hw = yg_h4_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ya_q <= {{(HW-ZW){yaw_ang[ZW-1]}}, yaw_ang} +
              (yaw_ang[ZW-1] ? qhpr_pkg::ANG_360_H : '0);
      yb_q <= ya_q + (HW'(cfg_i.offset) <<< 16);
      yc_q <= yc_d;
      yd_h_q <= yc_q;
      seg_q <= seg;
      frac_q <= frac;
      ye_h_q <= yd_h_q;
      ye_p_q <= prod;
      ye_d0_q <= d0;
      yf_h_q <= ye_h_q;
      yf_d0_q <= ye_d0_q;
      yf_a_q <= abs_p;
      yf_neg_q <= ye_p_q[PW-1];
      yf_q0_q <= recip[qhpr_pkg::DIV45_S +: QW];
      yg_h3_q <= yf_h_q;
      yg_h4_q <= h4;
      ydl_q[0] <= hw[24:9];
      for (int k = 1; k < YDLY; k++) begin
        ydl_q[k] <= ydl_q[k-1];
      end
    end
  end

  assign pa_sat = sat90(pa_ang);
  assign ra_sat = sat90(ra_ang);

  always_ff @(posedge clk_i) begin
    if (en) begin
      yaw_o <= ydl_q[YDLY-1];
      pitch_o <= pa_sat[23:9];
      roll_o <= ra_sat[23:9];
    end
  end

endmodule

FILE: hdl/quaternion_to_heading_pitch_roll.sv
// Attitude quaternion to heading, pitch and roll.
//
// Input channel: drive quat_*_i and raise push; the request is taken on a
// clock edge with push high and full low. Result channel: while empty is low
// yaw_o, pitch_o and roll_o show the oldest result; pop takes it.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (deviation low, deviation high, heading offset, deviation enable).
// Throughput is one request per cycle while full stays low. A request passes
// the input register, the queue, two chained CORDIC passes of CORDIC_STEPS
// pipelined stages each, the inverse-gain multiply and the output register.
// When pop is held off the back pipeline holds; the input register and the
// four-entry queue keep accepting up to five more requests before full rises.
// Reset empties the pipeline and loads the default configuration.
module quaternion_to_heading_pitch_roll #(
  parameter int QUAT_FRAC_BITS = 14,
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic signed [15:0] quat_w_i,
  input  logic signed [15:0] quat_x_i,
  input  logic signed [15:0] quat_y_i,
  input  logic signed [15:0] quat_z_i,
  output logic               empty,
  input  logic               pop,
  output logic [15:0]        yaw_o,
  output logic signed [14:0] pitch_o,
  output logic signed [14:0] roll_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i
);

  localparam int BW = (2 * QUAT_FRAC_BITS + 2 > 34) ? 2 * QUAT_FRAC_BITS + 2 : 34;

  qhpr_pkg::cfg_t cfg_q;
  logic q_wr, q_full, q_rd, q_empty;
  logic [5*BW-1:0] q_wdata, q_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dev_low <= qhpr_pkg::DEV_LOW_RST;
      cfg_q.dev_high <= qhpr_pkg::DEV_HIGH_RST;
      cfg_q.offset <= qhpr_pkg::OFFSET_RST;
      cfg_q.dev_en <= qhpr_pkg::DEV_EN_RST;
    end else if (cfg_we_i) begin
      case (qhpr_pkg::cfg_reg_e'(cfg_idx_i))
        qhpr_pkg::REG_DEV_LOW:  cfg_q.dev_low <= cfg_data_i;
        qhpr_pkg::REG_DEV_HIGH: cfg_q.dev_high <= cfg_data_i;
        qhpr_pkg::REG_OFFSET:   cfg_q.offset <= cfg_data_i[8:0];
        qhpr_pkg::REG_DEV_EN:   cfg_q.dev_en <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  qhpr_front #(.QUAT_FRAC_BITS(QUAT_FRAC_BITS), .BW(BW)) u_front (
    .clk_i, .rst_ni,
    .push_i(push), .full_o(full),
    .quat_w_i, .quat_x_i, .quat_y_i, .quat_z_i,
    .qfull_i(q_full), .wr_o(q_wr), .vec_o(q_wdata)
  );

  qhpr_fifo #(.W(5 * BW), .DEPTH(qhpr_pkg::QUEUE_DEPTH)) u_queue (
    .clk_i, .rst_ni,
    .wr_i(q_wr), .wdata_i(q_wdata), .full_o(q_full),
    .rd_i(q_rd), .rdata_o(q_rdata), .empty_o(q_empty)
  );

  qhpr_back #(.CORDIC_STEPS(CORDIC_STEPS), .BW(BW)) u_back (
    .clk_i, .rst_ni,
    .cfg_i(cfg_q),
    .qempty_i(q_empty), .qdata_i(q_rdata), .qrd_o(q_rd),
    .pop_i(pop), .empty_o(empty),
    .yaw_o, .pitch_o, .roll_o
  );

endmodule

FILE: hdl/qhpr_checker.sv
module qhpr_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               empty,
  input logic               pop,
  input logic [15:0]        yaw_o,
  input logic signed [14:0] pitch_o,
  input logic signed [14:0] roll_o
);

  // hold a result that was not taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(yaw_o) && $stable(pitch_o) && $stable(roll_o)))
    else $error("result changed while stalled");

  a_pitch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (pitch_o <= 15'sd11520 && pitch_o >= -15'sd11520))
    else $error("pitch beyond saturation");

  a_roll: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (roll_o <= 15'sd11520 && roll_o >= -15'sd11520))
    else $error("roll beyond saturation");

endmodule

bind quaternion_to_heading_pitch_roll qhpr_checker u_checker (.*);

FILE: verif/tb_quaternion_to_heading_pitch_roll.sv
`timescale 1ns / 1ps

module tb_quaternion_to_heading_pitch_roll;

  localparam longint ONE_DEG = 64'sd65536;
  localparam longint DEG45 = 45 * ONE_DEG;
  localparam longint DEG90 = 90 * ONE_DEG;
  localparam longint DEG360 = 360 * ONE_DEG;
  localparam longint unsigned GAIN_Q30 = 64'd652032874;
  localparam int STEPS = 16;
  localparam int FRAC = 14;
  localparam int SETTLE = 2 * STEPS + 12;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [15:0] yaw;
    logic [14:0] pitch;
    logic [14:0] roll;
  } attitude_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  logic signed [15:0] quat_w_i = '0, quat_x_i = '0, quat_y_i = '0, quat_z_i = '0;
  logic empty;
  logic pop = 1'b0;
  logic [15:0] yaw_o;
  logic signed [14:0] pitch_o, roll_o;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;

  logic [31:0] dev_lo_m = qhpr_pkg::DEV_LOW_RST, dev_hi_m = qhpr_pkg::DEV_HIGH_RST;
  logic [8:0] offset_m = qhpr_pkg::OFFSET_RST;
  logic dev_en_m = qhpr_pkg::DEV_EN_RST;

  attitude_t attitude_q[$];
  int mismatches = 0;
  int tx_idle_pct = 0, rx_stall_pct = 0;
  logic rx_hold = 1'b0;
  int cycles = 0;

  quaternion_to_heading_pitch_roll u_dut (.*);

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic longint vec_angle(longint xi, longint yi, output longint mag);
    longint x, y, z, xs, ys, t;
    x = xi; y = yi; z = 0;
    if (x == 0 && y == 0) begin
      mag = 0;
      return 0;
    end
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = DEG90;
      end else begin
        x = -y; y = t; z = -DEG90;
      end
    end
    for (int i = 0; i < STEPS; i++) begin
      xs = x >>> i; ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs; z += longint'(qhpr_pkg::atan_unit(i));
      end else begin
        x = x - ys; y = y + xs; z -= longint'(qhpr_pkg::atan_unit(i));
      end
    end
    mag = x;
    return z;
  endfunction

  function automatic longint tilt(longint num, longint a, longint b);
    longint mk, m, unused, ang;
    longint unsigned prod;
    unused = vec_angle(a, b, mk);
    if (mk < 0) mk = 0;
    prod = longint'(mk) * GAIN_Q30;
    m = longint'(prod >> 30);
    ang = vec_angle(m, num, unused);
    if (ang > DEG90) ang = DEG90;
    if (ang < -DEG90) ang = -DEG90;
    return ang;
  endfunction

  function automatic longint deviation_deg(int k);
    logic [31:0] r;
    logic signed [7:0] b;
    r = k[2] ? dev_hi_m : dev_lo_m;
    b = r[8*(k%4) +: 8];
    return longint'(b);
  endfunction

  function automatic attitude_t predict_attitude(logic signed [15:0] qw, logic signed [15:0] qx,
                                                 logic signed [15:0] qy, logic signed [15:0] qz);
    longint w, x, y, z, gx, gy, gz, yn, yd, h, unused, frac, d0, d1, p, r;
    int seg;
    attitude_t res;
    w = qw; x = qx; y = qy; z = qz;
    gx = 2 * (x * z - w * y);
    gy = 2 * (w * x + y * z);
    gz = w * w - x * x - y * y + z * z;
    yn = 2 * x * y - 2 * w * z;
    yd = 2 * w * w + 2 * x * x - (64'sd1 << (2 * FRAC));
    h = vec_angle(yd, yn, unused);
    if (h < 0) h += DEG360;
    h += longint'(offset_m) * ONE_DEG;
    repeat (3) if (h >= DEG360) h -= DEG360;
    if (dev_en_m) begin
      seg = int'(h / DEG45) & 7;
      frac = h - longint'(seg) * DEG45;
      d0 = deviation_deg(seg);
      d1 = deviation_deg((seg + 1) & 7);
      h += (frac * (d1 - d0)) / 45 + d0 * ONE_DEG;
      if (h < 0) h += DEG360;
      else if (h >= DEG360) h -= DEG360;
    end
    p = tilt(gx, gz, gy);
    r = tilt(gy, gz, gx);
    res.yaw = h[24:9];
    res.pitch = p[23:9];
    res.roll = r[23:9];
    return res;
  endfunction

  // result checker and receiver throttle
  always @(posedge clk_i) begin
    attitude_t exp_a;
    if (pop && !empty) begin
      if (attitude_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result yaw=%0d", yaw_o);
      end else begin
        exp_a = attitude_q.pop_front();
        if (exp_a.yaw !== yaw_o || exp_a.pitch !== pitch_o || exp_a.roll !== roll_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp yaw=%0d pitch=%0d roll=%0d, got yaw=%0d pitch=%0d roll=%0d",
                     exp_a.yaw, $signed(exp_a.pitch), $signed(exp_a.roll),
                     yaw_o, pitch_o, roll_o);
        end
      end
    end
    if (rx_hold) begin
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // hold off the receiver for a counted stretch
  task automatic hold_receiver(int n);
    rx_hold <= 1'b1;
    repeat (n) @(posedge clk_i);
    rx_hold <= 1'b0;
  endtask

  task automatic send_quat(logic signed [15:0] w, logic signed [15:0] x,
                           logic signed [15:0] y, logic signed [15:0] z);
    while ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    quat_w_i <= w; quat_x_i <= x; quat_y_i <= y; quat_z_i <= z;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    attitude_q.push_back(predict_attitude(w, x, y, z));
  endtask

  // hold off until every request has come back and the pipe is quiet
  task automatic drain;
    push <= 1'b0;
    @(posedge clk_i);
    while (attitude_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_config(logic [31:0] lo, logic [31:0] hi, logic [8:0] off, logic en);
    cfg_we_i <= 1'b1; cfg_idx_i <= qhpr_pkg::REG_DEV_LOW; cfg_data_i <= lo;
    @(posedge clk_i);
    cfg_idx_i <= qhpr_pkg::REG_DEV_HIGH; cfg_data_i <= hi;
    @(posedge clk_i);
    cfg_idx_i <= qhpr_pkg::REG_OFFSET; cfg_data_i <= {23'd0, off};
    @(posedge clk_i);
    cfg_idx_i <= qhpr_pkg::REG_DEV_EN; cfg_data_i <= {31'd0, en};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    dev_lo_m = lo; dev_hi_m = hi; offset_m = off; dev_en_m = en;
  endtask

  function automatic logic signed [15:0] rand_comp();
    if ($urandom_range(9) < 2) return 16'($urandom());
    return 16'(17'($urandom_range(32768)) - 17'd16384);
  endfunction

  task automatic send_random(int n);
    repeat (n) send_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
  endtask

  task automatic test_directed;
    tx_idle_pct = 0; rx_stall_pct = 0;
    send_quat(16'sd16384, 0, 0, 0);
    send_quat(-16'sd16384, 0, 0, 0);
    send_quat(0, 16'sd16384, 0, 0);
    send_quat(0, 0, 16'sd16384, 0);
    send_quat(0, 0, 0, 16'sd16384);
    send_quat(0, 0, 0, -16'sd16384);
    send_quat(0, 0, 0, 0);
    send_quat(-16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384);
    send_quat(16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384);
    send_quat(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_quat(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_quat(16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
    // gimbal lock: pitch at +-90 with zero denominator
    send_quat(16'sd11585, 0, 16'sd11585, 0);
    send_quat(16'sd11585, 0, -16'sd11585, 0);
    send_quat(16'sd11585, 16'sd11585, 0, 0);
    send_quat(16'sd11585, -16'sd11585, 0, 0);
    send_quat(16'sd11585, 0, 0, 16'sd11585);
    send_quat(16'sd11585, 0, 0, -16'sd11585);
    send_quat(16'sd15137, 0, 0, 16'sd6270);
    send_quat(16'sd6270, 0, 0, -16'sd15137);
    send_quat(16'sd1, 0, 0, 0);
    drain();
  endtask

  task automatic test_offset_extremes;
    write_config(32'h0, 32'h0, 9'd0, 1'b0);
    send_random(15);
    drain();
    write_config(32'h7F7F7F7F, 32'h80808080, 9'd359, 1'b1);
    send_random(15);
    send_quat(16'sd16384, 0, 0, 0);
    drain();
    // offset beyond 359 wraps like any heading
    write_config(32'h807F807F, 32'h7F807F80, 9'd511, 1'b1);
    send_random(15);
    drain();
  endtask

  task automatic test_random_phases;
    int pcts[4][2] = '{'{0, 0}, '{45, 0}, '{0, 45}, '{27, 27}};
    for (int ph = 0; ph < 4; ph++) begin
      write_config($urandom(), $urandom(), 9'($urandom_range(359)), 1'($urandom()));
      tx_idle_pct = pcts[ph][0]; rx_stall_pct = pcts[ph][1];
      send_random(400);
      drain();
    end
  endtask

  task automatic test_backpressure;
    write_config(qhpr_pkg::DEV_LOW_RST, qhpr_pkg::DEV_HIGH_RST, qhpr_pkg::OFFSET_RST,
                 qhpr_pkg::DEV_EN_RST);
    tx_idle_pct = 0; rx_stall_pct = 10;
    fork
      hold_receiver(300);
    join_none
    send_random(60);
    drain();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_offset_extremes();
    test_random_phases();
    test_backpressure();
    while (attitude_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (mismatches == 0 && attitude_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: quaternion_to_heading_pitch_roll.f
hdl/qhpr_pkg.sv
hdl/qhpr_front.sv
hdl/qhpr_fifo.sv
hdl/qhpr_cordic.sv
hdl/qhpr_back.sv
hdl/quaternion_to_heading_pitch_roll.sv
hdl/qhpr_checker.sv
verif/tb_quaternion_to_heading_pitch_roll.sv
